// ===== src/acm_pkg.sv =====
// shared types, constants and functions for the aes-256 cfb / cbc-mac engine
// no dependencies
package acm_pkg;

    typedef enum logic [1:0] {
        MODE_CFB_ENC = 2'd0,
        MODE_CFB_DEC = 2'd1,
        MODE_CBC_MAC = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam int unsigned AES_ROUNDS = 14;
    localparam int unsigned RI_W = 4;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_IVH  = 3'd4;
    localparam logic [2:0] REG_IVL  = 3'd5;
    localparam logic [2:0] REG_MODE = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take input word, set up cipher input, key schedule
        logic first;      // reload chain before use
        logic round;      // run one round
        logic last_round; // final round has no mixcolumns
        logic finish;     // form the result and update the chain
    } dp_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== src/acm_ctrl.sv =====
// controller for the aes-256 cfb / cbc-mac engine: sequences load, rounds, result
// depends on acm_pkg
module acm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              in_first,
    input  logic              in_last,
    input  acm_pkg::mode_t    mode,
    output acm_pkg::dp_cmd_t  cmd
);

    acm_pkg::state_t state_reg, state_next;
    logic [acm_pkg::RI_W-1:0] round_reg, round_next;
    logic emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acm_pkg::ST_IDLE;
            round_reg <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            acm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                // mode three swallows the word
                if (in_valid && mode != acm_pkg::MODE_NONE)
                begin
                    cmd.load   = 1'b1;
                    cmd.first  = in_first;
                    emit_next  = (mode != acm_pkg::MODE_CBC_MAC) || in_last;
                    round_next = {{(acm_pkg::RI_W-1){1'b0}}, 1'b1};
                    state_next = acm_pkg::ST_ROUND;
                end
            end
            acm_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                cmd.last_round = (round_reg == acm_pkg::RI_W'(acm_pkg::AES_ROUNDS));
                round_next = round_reg + 1'b1;
                if (cmd.last_round)
                    state_next = acm_pkg::ST_FINISH;
            end
            acm_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = emit_reg ? acm_pkg::ST_OUT : acm_pkg::ST_IDLE;
            end
            acm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = acm_pkg::ST_IDLE;
            end
            default:
                state_next = acm_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/acm_datapath.sv =====
// datapath: shared aes-256 round unit, on-the-fly key schedule, chain and result
// depends on acm_pkg
module acm_datapath
(
    input  logic              clk,
    input  acm_pkg::dp_cmd_t  cmd,
    input  acm_pkg::mode_t    mode,
    input  logic [255:0]      key,
    input  logic [127:0]      iv,
    input  logic [127:0]      blk_in,
    input  logic              last_in,
    input  logic              rst_n,
    output logic [127:0]      result,
    output logic              is_tag,
    output logic              end_of_message
);

    logic [127:0] state_reg, chain_reg, blk_reg, result_reg;
    logic [255:0] rk_reg;          // round keys i and i+1 (previous 8 words)
    logic [7:0]   rcon_reg;
    logic         odd_reg;         // next key half to derive is the sub_word kind
    logic         mac_reg, last_reg, enc_reg;

    logic [127:0] chain_use, sb, mc, rnd_out;
    logic [127:0] new_half;
    logic [31:0]  t0, w0, w1, w2, w3;

    assign chain_use = cmd.first ? ((mode == acm_pkg::MODE_CBC_MAC) ? '0 : iv) : chain_reg;

    // next four key words from the pair held in rk_reg
    always_comb
    begin
        t0 = odd_reg ? acm_pkg::sub_word(rk_reg[31:0])
                     : acm_pkg::sub_word({rk_reg[23:0], rk_reg[31:24]}) ^ {rcon_reg, 24'h0};
        w0 = rk_reg[255:224] ^ t0;
        w1 = rk_reg[223:192] ^ w0;
        w2 = rk_reg[191:160] ^ w1;
        w3 = rk_reg[159:128] ^ w2;
        new_half = {w0, w1, w2, w3};
    end

    // subbytes, shiftrows, mixcolumns, key add; column-major bytes, byte 0 at top
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[127 - 8*(4*c+r) -: 8] = acm_pkg::sbox(state_reg[127 - 8*(4*((c+r)%4)+r) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sb[127 - 32*c -: 8];
            a1 = sb[119 - 32*c -: 8];
            a2 = sb[111 - 32*c -: 8];
            a3 = sb[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127 - 32*c -: 8] = a0 ^ al ^ acm_pkg::xtime(a0 ^ a1);
            mc[119 - 32*c -: 8] = a1 ^ al ^ acm_pkg::xtime(a1 ^ a2);
            mc[111 - 32*c -: 8] = a2 ^ al ^ acm_pkg::xtime(a2 ^ a3);
            mc[103 - 32*c -: 8] = a3 ^ al ^ acm_pkg::xtime(a3 ^ a0);
        end
        // round key for this round is the lower (newer) half of the pair
        rnd_out = (cmd.last_round ? sb : mc) ^ rk_reg[127:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else if (cmd.load)
        begin
            chain_reg <= chain_use;
        end
        else if (cmd.finish)
        begin
            if (mac_reg)
                chain_reg <= state_reg;
            else if (enc_reg)
                chain_reg <= state_reg ^ blk_reg;
            else
                chain_reg <= blk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            state_reg <= ((mode == acm_pkg::MODE_CBC_MAC) ? (chain_use ^ blk_in) : chain_use)
                         ^ key[255:128];
            rk_reg    <= key;
            rcon_reg  <= 8'h01;
            odd_reg   <= 1'b0;
            blk_reg   <= blk_in;
            mac_reg   <= (mode == acm_pkg::MODE_CBC_MAC);
            enc_reg   <= (mode == acm_pkg::MODE_CFB_ENC);
            last_reg  <= last_in;
        end
        else if (cmd.round)
        begin
            state_reg <= rnd_out;
            rk_reg    <= {rk_reg[127:0], new_half};
            odd_reg   <= ~odd_reg;
            if (!odd_reg)
                rcon_reg <= acm_pkg::xtime(rcon_reg);
        end
        if (cmd.finish)
            result_reg <= mac_reg ? state_reg : (state_reg ^ blk_reg);
    end

    // rk_reg after load: upper 128 = key words 0..3, lower = words 4..7 (round 1);
    // each round shifts in the next four words so the lower half is that round's key
    assign result         = result_reg;
    assign is_tag         = mac_reg;
    assign end_of_message = last_reg;

endmodule

// ===== src/aes256_cfb_and_cbc_mac_engine_unit.sv =====
// top level of the aes-256 cfb-128 / cbc-mac engine: apb registers, controller, datapath
// depends on acm_pkg, acm_ctrl, acm_datapath
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------------
//  input    | in_valid / in_ready     | block_high, block_low, first_block, last_block
//  output   | out_valid / out_ready   | result_high, result_low, is_tag, end_of_message
//  config   | psel/penable/pwrite     | paddr, pwdata (64-bit), prdata
//
// a word goes to a result through a load step, fourteen passes through the
// single round unit (key schedule derived alongside), a finish step to form the result.
// mode three words and non-last mac words are consumed with no result.
// rst_n clears control state, chain and registers; the result waits for out_ready.
module aes256_cfb_and_cbc_mac_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        first_block,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic        is_tag,
    output logic        end_of_message
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, ivh_reg, ivl_reg;
    acm_pkg::mode_t mode_reg;
    acm_pkg::dp_cmd_t cmd;
    logic [127:0] result;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            ivh_reg  <= '0; ivl_reg  <= '0; mode_reg <= acm_pkg::MODE_CFB_ENC;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                acm_pkg::REG_KEY0: key0_reg <= pwdata;
                acm_pkg::REG_KEY1: key1_reg <= pwdata;
                acm_pkg::REG_KEY2: key2_reg <= pwdata;
                acm_pkg::REG_KEY3: key3_reg <= pwdata;
                acm_pkg::REG_IVH:  ivh_reg  <= pwdata;
                acm_pkg::REG_IVL:  ivl_reg  <= pwdata;
                acm_pkg::REG_MODE: mode_reg <= acm_pkg::mode_t'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            acm_pkg::REG_KEY0: prdata = key0_reg;
            acm_pkg::REG_KEY1: prdata = key1_reg;
            acm_pkg::REG_KEY2: prdata = key2_reg;
            acm_pkg::REG_KEY3: prdata = key3_reg;
            acm_pkg::REG_IVH:  prdata = ivh_reg;
            acm_pkg::REG_IVL:  prdata = ivl_reg;
            acm_pkg::REG_MODE: prdata = {62'h0, mode_reg};
            default:           prdata = '0;
        endcase
    end

    acm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_first  (first_block),
        .in_last   (last_block),
        .mode      (mode_reg),
        .cmd       (cmd)
    );

    acm_datapath u_dp
    (
        .clk            (clk),
        .cmd            (cmd),
        .mode           (mode_reg),
        .key            ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .iv             ({ivh_reg, ivl_reg}),
        .blk_in         ({block_high, block_low}),
        .last_in        (last_block),
        .rst_n          (rst_n),
        .result         (result),
        .is_tag         (is_tag),
        .end_of_message (end_of_message)
    );

    assign result_high = result[127:64];
    assign result_low  = result[63:0];

endmodule
